// File: rtl/dbmt_pkg.sv
// Shared constants, types and a helper function for the dirty bitmap block.
package dbmt_pkg;

   // Entry and word geometry
   localparam int WORD_BITS = 32;
   localparam int BIT_W = 5;
   localparam int INDEX_W = 10;
   localparam int LIMIT_W = 11;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
   localparam int DIRTY_WORDS_DEFAULT = 32;

   // Item operation codes
   typedef enum logic {
      OP_MARK = 1'b0,
      OP_TAKE = 1'b1
   } op_type;

   // Summary flag update for one word
   typedef struct packed {
      logic en;
      logic nonzero;
   } sum_upd_type;

   // Position of the lowest set bit of a word; 0 for an empty word
   function automatic logic [BIT_W-1:0] lowest_pos(input logic [WORD_BITS-1:0] w);
      logic [WORD_BITS-1:0] one_hot;
      logic [BIT_W-1:0] pos;
      one_hot = w & (~w + WORD_BITS'(1));
      pos = '0;
      for (int k = 0; k < BIT_W; k++) begin
         for (int j = 0; j < WORD_BITS; j++) begin
            if (((j >> k) & 1) == 1) begin
               pos[k] = pos[k] | one_hot[j];
            end
         end
      end
      return pos;
   endfunction

endpackage

// File: rtl/dirty_bitmap_mark_and_take.sv
// Top level: dirty bitmap with mark and take-lowest items.
// Operation: an accepted item's bitmap word is read into the registered RAM output,
// then modified and written back in the modify state, where a take waits while
// a held result is stalled; the take result then goes to the output register.
// A new item is accepted only once the read-modify-write of the last one is done.
// Reset: per-word flags clear at once (no clearing pass), index_limit returns to 1024.
module dirty_bitmap_mark_and_take #(
   parameter int DIRTY_WORDS = dbmt_pkg::DIRTY_WORDS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [dbmt_pkg::LIMIT_W-1:0]    csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_operation,
   input  logic [dbmt_pkg::INDEX_W-1:0]    req_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_found,
   output logic [dbmt_pkg::INDEX_W-1:0]    rsp_dirty_index
);

   localparam int AW = (DIRTY_WORDS > 1) ? $clog2(DIRTY_WORDS) : 1;
   localparam int POS_W = AW + dbmt_pkg::BIT_W;
   localparam int CAT_W = (POS_W > dbmt_pkg::INDEX_W) ? POS_W : dbmt_pkg::INDEX_W;

   typedef enum logic {
      ST_IDLE,
      ST_MODIFY
   } state_type;

   state_type                         state_ff, state_in;
   dbmt_pkg::op_type                  op_ff, op_in;
   logic [AW-1:0]                     addr_ff, addr_in;
   logic [dbmt_pkg::BIT_W-1:0]        bit_ff, bit_in;
   logic                              hit_ff, hit_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic [dbmt_pkg::INDEX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic [dbmt_pkg::LIMIT_W-1:0]      limit_ff;

   logic                              req_fire;
   logic                              out_free;
   logic [31:0]                       word_num;
   logic                              mark_ok;
   logic [AW-1:0]                     rd_addr;
   logic [dbmt_pkg::WORD_BITS-1:0]    rd_data;
   logic [dbmt_pkg::WORD_BITS-1:0]    cur_word;
   logic [dbmt_pkg::WORD_BITS-1:0]    wr_data;
   logic [dbmt_pkg::BIT_W-1:0]        take_pos;
   logic                              wr_en;
   logic                              done;
   logic [CAT_W-1:0]                  take_cat;
   dbmt_pkg::sum_upd_type             sum_upd;
   logic [DIRTY_WORDS-1:0]            flags;
   logic                              any_set;
   logic [AW-1:0]                     first_addr;

   // Limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= dbmt_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // Accept decode: word address, mark range check
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire = req_valid && !req_stall;
   assign word_num = 32'(req_index) >> dbmt_pkg::BIT_W;
   assign mark_ok = ({1'b0, req_index} < limit_ff) && (word_num < 32'(DIRTY_WORDS));
   assign rd_addr = (req_operation == dbmt_pkg::OP_TAKE) ? first_addr : word_num[AW-1:0];

   // Modify: words without a flag read as empty
   assign cur_word = flags[addr_ff] ? rd_data : '0;
   assign take_pos = dbmt_pkg::lowest_pos(cur_word);
   assign take_cat = CAT_W'({addr_ff, take_pos});

   always_comb begin
      if (op_ff == dbmt_pkg::OP_TAKE) begin
         wr_data = cur_word & ~(dbmt_pkg::WORD_BITS'(1) << take_pos);
      end else begin
         wr_data = cur_word | (dbmt_pkg::WORD_BITS'(1) << bit_ff);
      end
   end

   assign done = (state_ff == ST_MODIFY) && ((op_ff == dbmt_pkg::OP_MARK) || out_free);
   assign wr_en = done && hit_ff;
   assign sum_upd.en = wr_en;
   assign sum_upd.nonzero = |wr_data;

   // Next state and output register
   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      addr_in = addr_ff;
      bit_in = bit_ff;
      hit_in = hit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_MODIFY;
               op_in = dbmt_pkg::op_type'(req_operation);
               addr_in = rd_addr;
               bit_in = req_index[dbmt_pkg::BIT_W-1:0];
               hit_in = (req_operation == dbmt_pkg::OP_TAKE) ? any_set : mark_ok;
            end
         end
         ST_MODIFY: begin
            if (done) begin
               state_in = ST_IDLE;
               if (op_ff == dbmt_pkg::OP_TAKE) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = hit_ff;
                  rsp_index_in = hit_ff ? take_cat[dbmt_pkg::INDEX_W-1:0] : '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      addr_ff <= addr_in;
      bit_ff <= bit_in;
      hit_ff <= hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_dirty_index = rsp_index_ff;

   dbmt_word_ram #(
      .DEPTH(DIRTY_WORDS),
      .AW(AW)
   ) u_ram (
      .clock(clock),
      .rd_en(req_fire),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en(wr_en),
      .wr_addr(addr_ff),
      .wr_data(wr_data)
   );

   dbmt_summary #(
      .DEPTH(DIRTY_WORDS),
      .AW(AW)
   ) u_summary (
      .clock(clock),
      .reset(reset),
      .upd(sum_upd),
      .upd_addr(addr_ff),
      .flags(flags),
      .any_set(any_set),
      .first_addr(first_addr)
   );

`ifndef NO_ASSERTIONS
   // An accepted item always spends its next cycle in the modify step
   a_fire_to_modify: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_MODIFY)
      else $error("accepted item did not enter modify");

   // A take that finds nothing only happens on an empty bitmap
   a_miss_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MODIFY && op_ff == dbmt_pkg::OP_TAKE && !hit_ff) |-> !any_set)
      else $error("take missed a flagged word");

   // A take hit clears exactly one bit of a nonempty word
   a_take_clears_one: assert property (@(posedge clock) disable iff (reset)
      (wr_en && op_ff == dbmt_pkg::OP_TAKE) |->
         ($countones(wr_data) + 1 == $countones(cur_word)))
      else $error("take did not clear exactly one bit");

   // A result is loaded only as a take finishes
   a_rsp_from_take: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && rsp_stall)) |->
         (done && op_ff == dbmt_pkg::OP_TAKE))
      else $error("result loaded without a finishing take");
`endif

endmodule

// File: rtl/dbmt_word_ram.sv
// Bitmap word memory: one write port, one read port with registered read data.
module dbmt_word_ram #(
   parameter int DEPTH = dbmt_pkg::DIRTY_WORDS_DEFAULT,
   parameter int AW = 5
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [AW-1:0]                  rd_addr,
   output logic [dbmt_pkg::WORD_BITS-1:0] rd_data,
   input  logic                           wr_en,
   input  logic [AW-1:0]                  wr_addr,
   input  logic [dbmt_pkg::WORD_BITS-1:0] wr_data
);

   logic [dbmt_pkg::WORD_BITS-1:0] mem [DEPTH];
   logic [dbmt_pkg::WORD_BITS-1:0] rd_data_ff;

   // Write the modified word back
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read a word, hold it until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/dbmt_summary.sv
// Per-word nonzero flags and lowest-nonzero-word search.
module dbmt_summary #(
   parameter int DEPTH = dbmt_pkg::DIRTY_WORDS_DEFAULT,
   parameter int AW = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dbmt_pkg::sum_upd_type    upd,
   input  logic [AW-1:0]            upd_addr,
   output logic [DEPTH-1:0]         flags,
   output logic                     any_set,
   output logic [AW-1:0]            first_addr
);

   logic [DEPTH-1:0] flags_ff;
   logic [DEPTH-1:0] flags_in;
   logic [DEPTH-1:0] first_hot;

   // Set or clear the flag of the word just written
   always_comb begin
      flags_in = flags_ff;
      if (upd.en) begin
         flags_in[upd_addr] = upd.nonzero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   // Isolate the lowest flagged word and encode its address
   always_comb begin
      first_hot = flags_ff & (~flags_ff + DEPTH'(1));
      first_addr = '0;
      for (int k = 0; k < AW; k++) begin
         for (int j = 0; j < DEPTH; j++) begin
            if (((j >> k) & 1) == 1) begin
               first_addr[k] = first_addr[k] | first_hot[j];
            end
         end
      end
   end

   assign flags = flags_ff;
   assign any_set = |flags_ff;

endmodule

// File: test/testbench.sv
// Self-checking testbench for the dirty bitmap mark and take block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAP_WORDS = dbmt_pkg::DIRTY_WORDS_DEFAULT;
   localparam int HOLD_CYCLES = 150;
   localparam int SETTLE_CYCLES = 4;

   typedef struct packed {
      logic                         found;
      logic [dbmt_pkg::INDEX_W-1:0] index;
   } take_rsp_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_wr_en = 1'b0;
   logic [dbmt_pkg::LIMIT_W-1:0] csr_wr_data = '0;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_operation = dbmt_pkg::OP_MARK;
   logic [dbmt_pkg::INDEX_W-1:0] req_index = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_found;
   logic [dbmt_pkg::INDEX_W-1:0] rsp_dirty_index;

   // Predicted state of the block
   logic [dbmt_pkg::WORD_BITS-1:0] dirty_map [MAP_WORDS];
   logic [dbmt_pkg::LIMIT_W-1:0]   limit_now = dbmt_pkg::LIMIT_RESET;
   int                             dirty_count = 0;
   take_rsp_type                   pending_takes [$];

   // Run control and statistics
   bit idle_on = 1'b1;
   int holds_asked = 0;
   int holds_served = 0;
   int hold_left = 0;
   int burst_left = 0;
   int mismatches = 0;
   int takes_checked = 0;
   int marks_sent = 0;
   int takes_sent = 0;
   int found_seen = 0;
   int empty_seen = 0;
   int limits_used = 0;

   dirty_bitmap_mark_and_take #(
      .DIRTY_WORDS(MAP_WORDS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_index(req_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_found(rsp_found),
      .rsp_dirty_index(rsp_dirty_index)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      foreach (dirty_map[w]) dirty_map[w] = '0;
   end

   // Set the bit for a mark below the limit
   function automatic void mark_bitmap(input logic [dbmt_pkg::INDEX_W-1:0] idx);
      if ({1'b0, idx} < limit_now && !dirty_map[idx[9:5]][idx[4:0]]) begin
         dirty_map[idx[9:5]][idx[4:0]] = 1'b1;
         dirty_count++;
      end
   endfunction

   // Find, clear and return the lowest dirty entry
   function automatic take_rsp_type take_lowest();
      take_rsp_type r;
      r = '0;
      for (int w = 0; w < MAP_WORDS; w++) begin
         for (int b = 0; b < dbmt_pkg::WORD_BITS; b++) begin
            if (!r.found && dirty_map[w][b]) begin
               r.found = 1'b1;
               r.index = dbmt_pkg::INDEX_W'(w * dbmt_pkg::WORD_BITS + b);
               dirty_map[w][b] = 1'b0;
               dirty_count--;
            end
         end
      end
      return r;
   endfunction

   // Offer one item, hold it until accepted, then update the prediction
   task automatic send_item(input dbmt_pkg::op_type op,
                            input logic [dbmt_pkg::INDEX_W-1:0] idx);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == dbmt_pkg::OP_MARK) begin
         marks_sent++;
         mark_bitmap(idx);
      end else begin
         takes_sent++;
         pending_takes.push_back(take_lowest());
      end
   endtask

   // Drop valid and wait until every take has answered and the block is quiet
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_takes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [dbmt_pkg::LIMIT_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_now = value;
      limits_used++;
   endtask

   // Index near zero, anywhere, or around the current limit
   function automatic logic [dbmt_pkg::INDEX_W-1:0] pick_index();
      int lo;
      int hi;
      case ($urandom_range(0, 2))
         0: begin
            lo = 0;
            hi = 63;
         end
         1: begin
            lo = 0;
            hi = 1023;
         end
         default: begin
            lo = (int'(limit_now) > 40) ? int'(limit_now) - 40 : 0;
            hi = (int'(limit_now) + 40 < 1023) ? int'(limit_now) + 40 : 1023;
            if (lo > hi) lo = hi;
         end
      endcase
      return dbmt_pkg::INDEX_W'($urandom_range(lo, hi));
   endfunction

   task automatic run_mix(input int count, input int mark_pct);
      for (int i = 0; i < count; i++) begin
         send_item(($urandom_range(0, 99) < mark_pct) ? dbmt_pkg::OP_MARK : dbmt_pkg::OP_TAKE,
                   pick_index());
      end
   endtask

   // Mark a batch, then take until one take comes back empty
   task automatic fill_and_drain(input int marks);
      int n;
      for (int i = 0; i < marks; i++) send_item(dbmt_pkg::OP_MARK, pick_index());
      n = dirty_count + 1;
      for (int i = 0; i < n; i++) begin
         send_item(dbmt_pkg::OP_TAKE, dbmt_pkg::INDEX_W'($urandom_range(0, 1023)));
      end
   endtask

   task automatic test_empty_and_order();
      send_item(dbmt_pkg::OP_TAKE, '1);
      send_item(dbmt_pkg::OP_MARK, 10'd1023);
      send_item(dbmt_pkg::OP_MARK, 10'd0);
      send_item(dbmt_pkg::OP_MARK, 10'd31);
      send_item(dbmt_pkg::OP_MARK, 10'd32);
      send_item(dbmt_pkg::OP_MARK, 10'd5);
      send_item(dbmt_pkg::OP_MARK, 10'd5);
      repeat (6) send_item(dbmt_pkg::OP_TAKE, 10'd0);
      wait_drain();
   endtask

   task automatic test_limit_edges();
      // no mark takes effect at limit zero
      write_limit(11'd0);
      send_item(dbmt_pkg::OP_MARK, 10'd0);
      send_item(dbmt_pkg::OP_TAKE, 10'd0);
      wait_drain();
      // only entry zero at limit one
      write_limit(11'd1);
      send_item(dbmt_pkg::OP_MARK, 10'd1);
      send_item(dbmt_pkg::OP_MARK, 10'd0);
      send_item(dbmt_pkg::OP_TAKE, 10'd0);
      send_item(dbmt_pkg::OP_TAKE, 10'd0);
      wait_drain();
      // top index at the widest limit, then lower the limit under a set bit
      write_limit(11'd2047);
      send_item(dbmt_pkg::OP_MARK, 10'd1023);
      wait_drain();
      write_limit(11'd16);
      send_item(dbmt_pkg::OP_TAKE, 10'd0);
      send_item(dbmt_pkg::OP_TAKE, 10'd0);
      wait_drain();
   endtask

   task automatic test_random_phases();
      logic [dbmt_pkg::LIMIT_W-1:0] limits [7];
      limits = '{11'd1024, 11'd2047, dbmt_pkg::LIMIT_W'($urandom_range(0, 2047)), 11'd64,
                 11'd1, 11'd0, 11'd1000};
      foreach (limits[p]) begin
         write_limit(limits[p]);
         run_mix(120, $urandom_range(45, 65));
         fill_and_drain($urandom_range(20, 40));
         wait_drain();
      end
   endtask

   task automatic test_output_hold();
      write_limit(dbmt_pkg::LIMIT_RESET);
      holds_asked++;
      for (int i = 0; i < 60; i++) begin
         send_item((i % 3 == 0) ? dbmt_pkg::OP_MARK : dbmt_pkg::OP_TAKE, pick_index());
      end
      wait_drain();
   endtask

   task automatic test_full_rate();
      idle_on = 1'b0;
      write_limit(dbmt_pkg::LIMIT_W'($urandom_range(512, 2047)));
      run_mix(120, 55);
      wait_drain();
   endtask

   // Receiver: long hold on request, else short random stall bursts
   always @(posedge clock) begin
      if (holds_served != holds_asked) begin
         holds_served <= holds_asked;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (burst_left > 0) begin
         burst_left <= burst_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         burst_left <= $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted result with the oldest predicted take
   always @(posedge clock) begin
      take_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_takes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: found %0b index %0d", rsp_found, rsp_dirty_index);
         end else begin
            want = pending_takes.pop_front();
            takes_checked++;
            if (want.found) found_seen++;
            else empty_seen++;
            if (rsp_found !== want.found || rsp_dirty_index !== want.index) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("take %0d: found exp %0b got %0b, index exp %0d got %0d",
                           takes_checked, want.found, rsp_found, want.index,
                           rsp_dirty_index);
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_order();
      test_limit_edges();
      test_random_phases();
      test_output_hold();
      test_full_rate();
      repeat (10) @(posedge clock);
      $display("Sent %0d marks and %0d takes over %0d limit settings.",
               marks_sent, takes_sent, limits_used);
      $display("Checked %0d takes: %0d found, %0d empty, %0d mismatches.",
               takes_checked, found_seen, empty_seen, mismatches);
      if (mismatches == 0 && pending_takes.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("timeout with %0d takes outstanding", pending_takes.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: sim.f
rtl/dbmt_pkg.sv
rtl/dbmt_word_ram.sv
rtl/dbmt_summary.sv
rtl/dirty_bitmap_mark_and_take.sv
test/testbench.sv
